// ===== hw/rtl/trlc_pkg.sv =====
// Shared types, codes and defaults for the tree route length calculator.
package trlc_pkg;

	// Default parameter values
	localparam int NODE_BITS_DEF  = 16;
	localparam int MAX_LEVELS_DEF = 16;

	// Field and register widths
	localparam int NODE_FIELD_W = 16;
	localparam int ROUTE_W      = 6;
	localparam int STATUS_W     = 2;
	localparam int TOPO_W       = 2;
	localparam int ARITY_W      = 8;
	localparam int UP_W         = 32;   // up-arity power saturates at 2^32-1
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_ARITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_ARITY   = 2'd2;

	// Topology codes (code three behaves as k-ary n-tree)
	localparam logic [TOPO_W-1:0] TOPO_KARY = 2'd0;
	localparam logic [TOPO_W-1:0] TOPO_THIN = 2'd1;
	localparam logic [TOPO_W-1:0] TOPO_SLIM = 2'd2;

	// Register reset values
	localparam logic [TOPO_W-1:0]  TOPO_RST       = TOPO_KARY;
	localparam logic [ARITY_W-1:0] DOWN_ARITY_RST = 8'd2;
	localparam logic [ARITY_W-1:0] UP_ARITY_RST   = 8'd1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_SELF  = 2'd1,
		STATUS_LIMIT = 2'd2
	} status_t;

	// Request word
	typedef struct packed {
		logic [NODE_FIELD_W-1:0] source_node;
		logic [NODE_FIELD_W-1:0] dest_node;
	} req_t;

	// Response word
	typedef struct packed {
		logic [ROUTE_W-1:0]  route_length;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

// ===== hw/rtl/trlc_div.sv =====
// Two-lane restoring divider, one quotient bit per lane per cycle, shared divisor.
module trlc_div #(
	parameter int NUM_W = trlc_pkg::UP_W + trlc_pkg::NODE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num_a,
	input  logic [NUM_W-1:0] num_b,
	input  logic [NUM_W:0]   divisor,
	output logic             done,
	output logic [NUM_W-1:0] quo_a,
	output logic [NUM_W-1:0] quo_b
);
	import trlc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [NUM_W:0]   d_q;
	logic [NUM_W-1:0] n_q   [2];
	logic [NUM_W:0]   r_q   [2];
	logic [NUM_W-1:0] n_nxt [2];
	logic [NUM_W:0]   r_nxt [2];

	// One restoring step per lane: shift in next numerator bit, try subtract
	always_comb begin
		logic [NUM_W+1:0] trial;
		logic [NUM_W+1:0] diff;
		logic             ge;
		for (int i = 0; i < 2; i++) begin
			trial    = {r_q[i], n_q[i][NUM_W-1]};
			diff     = trial - {1'b0, d_q};
			ge       = (trial >= {1'b0, d_q});
			r_nxt[i] = ge ? diff[NUM_W:0] : trial[NUM_W:0];
			n_nxt[i] = {n_q[i][NUM_W-2:0], ge};
		end
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Datapath: numerator shifts out, quotient shifts in behind it
	always_ff @(posedge clk) begin
		if (start) begin
			n_q[0] <= num_a;
			n_q[1] <= num_b;
			r_q[0] <= '0;
			r_q[1] <= '0;
			d_q    <= divisor;
		end else if (cnt_q != '0) begin
			n_q[0] <= n_nxt[0];
			n_q[1] <= n_nxt[1];
			r_q[0] <= r_nxt[0];
			r_q[1] <= r_nxt[1];
		end
	end

	assign done  = done_q;
	assign quo_a = n_q[0];
	assign quo_b = n_q[1];

endmodule

// ===== hw/rtl/tree_route_length_calculator.sv =====
// Top level: nearest common ancestor level search over a multistage tree.
//
//   channel   signals                       direction  transfer
//   --------  ----------------------------  ---------  -----------------------------
//   request   start, busy, req              in         start & !busy at clock edge
//   response  rsp_valid, rsp                out        one-cycle strobe, no backpressure
//   config    cfg_we, cfg_index, cfg_data   in         cfg_we at clock edge
//
// A self-sent word answers in the next cycle. Otherwise each level tried costs
// one pass of the bit-serial divider over NUM_W = 32 + id bits (48 at defaults);
// a word runs one pass per level up to its ancestor level L, up to MAX_LEVELS
// levels. busy is high for the whole search.
// Reset clears control and configuration; no clearing pass is needed.
// The receiver cannot stall: each result shows for exactly one cycle.
module tree_route_length_calculator #(
	parameter int NODE_BITS  = trlc_pkg::NODE_BITS_DEF,
	parameter int MAX_LEVELS = trlc_pkg::MAX_LEVELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  trlc_pkg::req_t                  req,
	output logic                            rsp_valid,
	output trlc_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [trlc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trlc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import trlc_pkg::*;

	localparam int ID_W  = (NODE_BITS < NODE_FIELD_W) ? NODE_BITS : NODE_FIELD_W;
	localparam int NUM_W = UP_W + ID_W;
	localparam int LVL_W = $clog2(MAX_LEVELS + 1);
	localparam int DP_W  = NUM_W + 1 + ARITY_W;
	localparam int UPP_W = UP_W + ARITY_W;
	// Any divisor at or above 2^NUM_W gives a zero quotient
	localparam logic [NUM_W:0] DPOW_CAP = {1'b1, {NUM_W{1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LOAD  = 4'b0010,
		S_DIV   = 4'b0100,
		S_CHECK = 4'b1000
	} state_t;

	state_t              state_q;
	logic [TOPO_W-1:0]   topo_q;
	logic [ARITY_W-1:0]  down_q;
	logic [ARITY_W-1:0]  up_q;
	logic [ID_W-1:0]     src_q;
	logic [ID_W-1:0]     dst_q;
	logic [UP_W-1:0]     upow_q;
	logic [NUM_W:0]      dpow_q;
	logic [LVL_W-1:0]    level_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [ARITY_W-1:0]  k;
	logic [ID_W-1:0]     src_in;
	logic [ID_W-1:0]     dst_in;
	logic [DP_W-1:0]     dpow_prod;
	logic [NUM_W:0]      dpow_nxt;
	logic [UPP_W-1:0]    upow_prod;
	logic [UP_W-1:0]     upow_nxt;
	logic [NUM_W-1:0]    num_a;
	logic [NUM_W-1:0]    num_b;
	logic                div_start;
	logic                div_done;
	logic [NUM_W-1:0]    quo_a;
	logic [NUM_W-1:0]    quo_b;
	logic [LVL_W:0]      level_dbl;
	logic                at_limit;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topo_q <= TOPO_RST;
			down_q <= DOWN_ARITY_RST;
			up_q   <= UP_ARITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOPOLOGY:   topo_q <= cfg_data[TOPO_W-1:0];
				CFG_DOWN_ARITY: down_q <= cfg_data;
				CFG_UP_ARITY:   up_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operands and saturating power updates
	assign k      = (down_q == '0) ? ARITY_W'(1) : down_q;
	assign src_in = req.source_node[ID_W-1:0];
	assign dst_in = req.dest_node[ID_W-1:0];

	assign dpow_prod = DP_W'(dpow_q) * DP_W'(k);
	assign dpow_nxt  = (dpow_prod > DP_W'(DPOW_CAP)) ? DPOW_CAP : dpow_prod[NUM_W:0];
	assign upow_prod = UPP_W'(upow_q) * UPP_W'(up_q);
	assign upow_nxt  = (|upow_prod[UPP_W-1:UP_W]) ? '1 : upow_prod[UP_W-1:0];

	// Scaled ids feed the divider straight into its load registers
	assign num_a     = NUM_W'(upow_q) * NUM_W'(src_q);
	assign num_b     = NUM_W'(upow_q) * NUM_W'(dst_q);
	assign div_start = (state_q == S_LOAD);

	trlc_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_a  (num_a),
		.num_b  (num_b),
		.divisor(dpow_q),
		.done   (div_done),
		.quo_a  (quo_a),
		.quo_b  (quo_b)
	);

	assign level_dbl = {level_q, 1'b0};
	assign at_limit  = (level_q >= LVL_W'(MAX_LEVELS));

	// Sequencer: one level per divider pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			level_q     <= '0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						level_q <= LVL_W'(1);
						if (src_in == dst_in) begin
							rsp_valid_q <= 1'b1;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (quo_a == quo_b || at_limit) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						level_q <= level_q + LVL_W'(1);
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Search datapath and response word
	always_ff @(posedge clk) begin
		priority if (state_q == S_IDLE && start) begin
			src_q  <= src_in;
			dst_q  <= dst_in;
			upow_q <= UP_W'(1);
			dpow_q <= (NUM_W + 1)'(k);
			rsp_q.route_length <= '0;
			rsp_q.status       <= STATUS_SELF;
		end else if (state_q == S_CHECK) begin
			rsp_q.route_length <= ROUTE_W'(level_dbl);
			rsp_q.status       <= (quo_a == quo_b) ? STATUS_OK : STATUS_LIMIT;
			dpow_q <= dpow_nxt;
			// slim tree scales the ids from level three on
			if (topo_q == TOPO_SLIM && level_q != LVL_W'(1)) begin
				upow_q <= upow_nxt;
			end
		end else begin
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/trlc_chk.sv =====
// Port-level checker for the tree route length calculator, with its bind.
module trlc_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input trlc_pkg::req_t req,
	input logic           rsp_valid,
	input trlc_pkg::rsp_t rsp
);
	import trlc_pkg::*;

	// A self-sent word answers on the next cycle with the self status
	a_self_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.source_node == req.dest_node)
		|=> (rsp_valid && rsp.status == STATUS_SELF))
		else $error("self-sent word not answered at once");

	// Self status carries a zero route length
	a_self_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STATUS_SELF) |-> (rsp.route_length == '0))
		else $error("self status with nonzero route length");

	// An accepted word either answers at once or starts a search
	a_accept_acts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || rsp_valid))
		else $error("accepted word dropped");

	// A search ends only with a result word
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> rsp_valid)
		else $error("search ended without a result");

endmodule

bind tree_route_length_calculator trlc_chk u_trlc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp      (rsp)
);
